FILE: rtl/core/first_substring_match_top_macros.svh
// Assertion helpers for the first substring match block.
// All checks are clocked on clk and held off while rst_n is low.
`ifndef FIRST_SUBSTRING_MATCH_TOP_MACROS_SVH
`define FIRST_SUBSTRING_MATCH_TOP_MACROS_SVH

// cond and ok_cond must hold in the same cycle
`define FSMATCH_ASSERT_NOW(label, cond, ok_cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (ok_cond)) \
        else $error(msg);

// ok_cond must hold in the cycle after cond
`define FSMATCH_ASSERT_NEXT(label, cond, ok_cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (ok_cond)) \
        else $error(msg);

`endif

FILE: rtl/core/fsmatch_pkg.sv
package fsmatch_pkg;

    localparam logic MODE_PATTERN = 1'b0;
    localparam logic MODE_TEXT    = 1'b1;

    localparam int POS_W       = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic       mode;
        logic [7:0] byte_value;
        logic       last;
    } item_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] match_position;
        logic             overflow;
    } result_t;

    // work handed from the front to the back
    typedef enum logic [1:0] {
        OP_NEW_PAT,
        OP_ADD_PAT,
        OP_TEXT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] byte_value;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

FILE: rtl/core/fsmatch_front.sv
module fsmatch_front #(
    parameter int unsigned PATTERN_MAX = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_stall,
    input  fsmatch_pkg::item_t         item_data,
    input  fsmatch_pkg::queue_status_t q_stat,
    output logic                       q_push,
    output fsmatch_pkg::cmd_t          q_cmd
);

    localparam int PL_W = $clog2(PATTERN_MAX + 1);

    logic [PL_W-1:0] plen_reg, plen_next;
    logic            complete_reg, complete_next;
    logic            accept;

    assign item_stall = q_stat.full;
    assign accept     = item_valid && !q_stat.full;

    always_comb
    begin
        plen_next        = plen_reg;
        complete_next    = complete_reg;
        q_push           = 1'b0;
        q_cmd.op         = fsmatch_pkg::OP_TEXT;
        q_cmd.byte_value = item_data.byte_value;
        q_cmd.last       = item_data.last;
        if (accept)
        begin
            if (item_data.mode == fsmatch_pkg::MODE_PATTERN)
            begin
                if (complete_reg)
                begin
                    // a pattern byte after a complete pattern opens a new one
                    q_push        = 1'b1;
                    q_cmd.op      = fsmatch_pkg::OP_NEW_PAT;
                    plen_next     = PL_W'(1);
                    complete_next = item_data.last;
                end
                else
                begin
                    if (plen_reg < PL_W'(PATTERN_MAX))
                    begin
                        q_push    = 1'b1;
                        q_cmd.op  = (plen_reg == '0) ? fsmatch_pkg::OP_NEW_PAT
                                                     : fsmatch_pkg::OP_ADD_PAT;
                        plen_next = plen_reg + PL_W'(1);
                    end
                    if (item_data.last)
                    begin
                        complete_next = 1'b1;
                    end
                end
            end
            else
            begin
                // text before the pattern is complete is dropped here
                q_push = complete_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg     <= '0;
            complete_reg <= 1'b0;
        end
        else
        begin
            plen_reg     <= plen_next;
            complete_reg <= complete_next;
        end
    end

endmodule

FILE: rtl/core/fsmatch_queue.sv
module fsmatch_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  fsmatch_pkg::cmd_t          push_cmd,
    input  logic                       pop,
    output fsmatch_pkg::cmd_t          pop_cmd,
    output fsmatch_pkg::queue_status_t stat
);

    fsmatch_pkg::cmd_t slot_reg [fsmatch_pkg::QUEUE_DEPTH];

    logic [fsmatch_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [fsmatch_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [fsmatch_pkg::QUEUE_CNT_W-1:0] count_reg, count_next;

    assign stat.full  = (count_reg == fsmatch_pkg::QUEUE_CNT_W'(fsmatch_pkg::QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + fsmatch_pkg::QUEUE_PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + fsmatch_pkg::QUEUE_PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + fsmatch_pkg::QUEUE_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - fsmatch_pkg::QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: rtl/core/fsmatch_back.sv
module fsmatch_back #(
    parameter int unsigned      PATTERN_MAX = 32,
    parameter longint unsigned  TEXT_MAX    = 65536
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  fsmatch_pkg::cmd_t    q_cmd,
    output logic                 q_pop,
    output logic                 result_valid,
    input  logic                 result_stall,
    output fsmatch_pkg::result_t result_data
);

    localparam int PL_W = $clog2(PATTERN_MAX + 1);
    localparam int IX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int TP_W = $clog2(TEXT_MAX + 1);
    localparam logic [TP_W-1:0] TP_LIMIT = TP_W'(TEXT_MAX);

    typedef enum logic {
        ST_IDLE,
        ST_CMP
    } state_t;

    state_t                 state_reg, state_next;
    fsmatch_pkg::op_t       op_reg, op_next;
    logic [7:0]             byte_reg, byte_next;
    logic                   last_reg, last_next;
    logic [PL_W-1:0]        k_reg, k_next;
    logic [PL_W-1:0]        bml_reg, bml_next;
    logic [PL_W-1:0]        sml_reg, sml_next;
    logic [PL_W-1:0]        plen_reg, plen_next;
    logic [TP_W-1:0]        tp_reg, tp_next;
    logic                   ovf_reg, ovf_next;
    logic                   done_reg, done_next;
    logic                   res_valid_reg, res_valid_next;
    fsmatch_pkg::result_t   res_reg, res_next;

    logic [7:0]             pat_mem [PATTERN_MAX];
    logic [IX_W-1:0]        pfx_mem [PATTERN_MAX];
    logic [7:0]             pat_q_reg;
    logic [IX_W-1:0]        pfx_q_reg;

    logic                   pat_we;
    logic [IX_W-1:0]        pat_wa;
    logic                   pfx_we;
    logic [IX_W-1:0]        pfx_wa;
    logic [IX_W-1:0]        pfx_wd;
    logic                   rd_en;
    logic [PL_W-1:0]        rd_addr;
    logic [IX_W-1:0]        rd_idx;
    logic [IX_W-1:0]        rd_prev_idx;

    logic                   out_free;
    logic                   hit_byte;
    logic                   walk;
    logic [PL_W-1:0]        k_new;

    assign out_free     = !res_valid_reg || !result_stall;
    assign result_valid = res_valid_reg;
    assign result_data  = res_reg;

    // a text beat may end in a result, so it waits for room at the output
    assign q_pop = (state_reg == ST_IDLE) && q_valid
                   && ((q_cmd.op != fsmatch_pkg::OP_TEXT) || out_free);

    assign hit_byte    = (pat_q_reg == byte_reg);
    assign walk        = (k_reg != '0) && !hit_byte;
    assign k_new       = k_reg + PL_W'(hit_byte);
    assign rd_idx      = IX_W'(rd_addr);
    assign rd_prev_idx = IX_W'(rd_addr - PL_W'(1));

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        k_next         = k_reg;
        bml_next       = bml_reg;
        sml_next       = sml_reg;
        plen_next      = plen_reg;
        tp_next        = tp_reg;
        ovf_next       = ovf_reg;
        done_next      = done_reg;
        res_valid_next = res_valid_reg && result_stall;
        res_next       = res_reg;
        pat_we         = 1'b0;
        pat_wa         = '0;
        pfx_we         = 1'b0;
        pfx_wa         = '0;
        pfx_wd         = '0;
        rd_en          = 1'b0;
        rd_addr        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_pop)
                begin
                    op_next   = q_cmd.op;
                    byte_next = q_cmd.byte_value;
                    last_next = q_cmd.last;
                    case (q_cmd.op)
                        fsmatch_pkg::OP_NEW_PAT:
                        begin
                            pat_we    = 1'b1;
                            pfx_we    = 1'b1;
                            bml_next  = '0;
                            plen_next = PL_W'(1);
                            sml_next  = '0;
                            tp_next   = '0;
                            ovf_next  = 1'b0;
                            done_next = 1'b0;
                        end
                        fsmatch_pkg::OP_ADD_PAT:
                        begin
                            pat_we     = 1'b1;
                            pat_wa     = IX_W'(plen_reg);
                            rd_en      = 1'b1;
                            rd_addr    = bml_reg;
                            k_next     = bml_reg;
                            state_next = ST_CMP;
                        end
                        fsmatch_pkg::OP_TEXT:
                        begin
                            if (done_reg)
                            begin
                                // rest of a matched text is skipped
                                if (q_cmd.last)
                                begin
                                    sml_next  = '0;
                                    tp_next   = '0;
                                    ovf_next  = 1'b0;
                                    done_next = 1'b0;
                                end
                            end
                            else if (tp_reg < TP_LIMIT)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = sml_reg;
                                k_next     = sml_reg;
                                state_next = ST_CMP;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                                if (q_cmd.last)
                                begin
                                    res_valid_next          = 1'b1;
                                    res_next.found          = 1'b0;
                                    res_next.match_position = '0;
                                    res_next.overflow       = 1'b1;
                                    sml_next                = '0;
                                    tp_next                 = '0;
                                    ovf_next                = 1'b0;
                                    done_next               = 1'b0;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_CMP:
            begin
                if (walk)
                begin
                    // follow the failure link
                    k_next  = PL_W'(pfx_q_reg);
                    rd_en   = 1'b1;
                    rd_addr = PL_W'(pfx_q_reg);
                end
                else if (op_reg != fsmatch_pkg::OP_TEXT)
                begin
                    pfx_we     = 1'b1;
                    pfx_wa     = IX_W'(plen_reg);
                    pfx_wd     = IX_W'(k_new);
                    bml_next   = k_new;
                    plen_next  = plen_reg + PL_W'(1);
                    state_next = ST_IDLE;
                end
                else if (k_new == plen_reg)
                begin
                    if (out_free)
                    begin
                        res_valid_next          = 1'b1;
                        res_next.found          = 1'b1;
                        res_next.match_position = fsmatch_pkg::POS_W'(tp_reg)
                                                  + fsmatch_pkg::POS_W'(1)
                                                  - fsmatch_pkg::POS_W'(plen_reg);
                        res_next.overflow       = 1'b0;
                        sml_next                = '0;
                        if (last_reg)
                        begin
                            tp_next   = '0;
                            ovf_next  = 1'b0;
                            done_next = 1'b0;
                        end
                        else
                        begin
                            done_next = 1'b1;
                        end
                        state_next = ST_IDLE;
                    end
                end
                else if (last_reg)
                begin
                    if (out_free)
                    begin
                        res_valid_next          = 1'b1;
                        res_next.found          = 1'b0;
                        res_next.match_position = '0;
                        res_next.overflow       = 1'b0;
                        sml_next                = '0;
                        tp_next                 = '0;
                        ovf_next                = 1'b0;
                        done_next               = 1'b0;
                        state_next              = ST_IDLE;
                    end
                end
                else
                begin
                    sml_next   = k_new;
                    tp_next    = tp_reg + TP_W'(1);
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= fsmatch_pkg::OP_TEXT;
            byte_reg      <= '0;
            last_reg      <= 1'b0;
            k_reg         <= '0;
            bml_reg       <= '0;
            sml_reg       <= '0;
            plen_reg      <= '0;
            tp_reg        <= '0;
            ovf_reg       <= 1'b0;
            done_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            byte_reg      <= byte_next;
            last_reg      <= last_next;
            k_reg         <= k_next;
            bml_reg       <= bml_next;
            sml_reg       <= sml_next;
            plen_reg      <= plen_next;
            tp_reg        <= tp_next;
            ovf_reg       <= ovf_next;
            done_reg      <= done_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
        end
    end

    // pattern bytes and prefix lengths, one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (pat_we)
        begin
            pat_mem[pat_wa] <= q_cmd.byte_value;
        end
        if (pfx_we)
        begin
            pfx_mem[pfx_wa] <= pfx_wd;
        end
        if (rd_en)
        begin
            pat_q_reg <= pat_mem[rd_idx];
            pfx_q_reg <= pfx_mem[rd_prev_idx];
        end
    end

endmodule

FILE: rtl/core/first_substring_match_top.sv
// First substring match: finds where a byte pattern first occurs in a text stream (KMP).
// Input channel item_valid/item_stall/item_data: mode 0 beats load the pattern, mode 1
// beats carry text; last closes the pattern or the text. A pattern beat after a complete
// pattern starts a new pattern; text beats before the pattern is complete are dropped.
// Output channel result_valid/result_stall/result_data: one beat per text stream, at the
// first match (found, start position) or at the last text beat (not found, overflow if
// the text ran past TEXT_MAX bytes).
// A front stage takes one beat per cycle into a 4-entry command queue; item_stall is
// raised only while that queue is full.
// The back engine handles a first pattern byte, a skipped text byte or a text byte past
// TEXT_MAX in the idle state alone; any other byte also enters the compare state, which
// follows one failure link per step. Links only shorten the matched prefix. An overflow
// miss is registered to result_valid from the idle state, any other result from the
// compare state once its link steps are done; a beat may first wait in the queue.
// While result_stall is high the result is held; the engine starts no further text beat
// until the output register is free, so the queue fills and raises item_stall.
// Reset clears all control state and the current pattern; the memories need no clearing.
`include "first_substring_match_top_macros.svh"

module first_substring_match_top #(
    parameter int unsigned     PATTERN_MAX = 32,
    parameter longint unsigned TEXT_MAX    = 65536
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  fsmatch_pkg::item_t   item_data,
    output logic                 result_valid,
    input  logic                 result_stall,
    output fsmatch_pkg::result_t result_data
);

    fsmatch_pkg::queue_status_t q_stat;
    fsmatch_pkg::cmd_t          q_push_cmd;
    fsmatch_pkg::cmd_t          q_cmd;
    logic                       q_push;
    logic                       q_pop;
    logic                       res_hit;
    logic                       res_miss;
    logic                       pat_pop;

    fsmatch_front #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item_data  (item_data),
        .q_stat     (q_stat),
        .q_push     (q_push),
        .q_cmd      (q_push_cmd)
    );

    fsmatch_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .pop      (q_pop),
        .pop_cmd  (q_cmd),
        .stat     (q_stat)
    );

    fsmatch_back #(
        .PATTERN_MAX (PATTERN_MAX),
        .TEXT_MAX    (TEXT_MAX)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (!q_stat.empty),
        .q_cmd        (q_cmd),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    assign res_hit  = result_valid && result_data.found;
    assign res_miss = result_valid && !result_data.found;
    assign pat_pop  = q_pop && (q_cmd.op != fsmatch_pkg::OP_TEXT);

    `FSMATCH_ASSERT_NOW(a_push_room, q_push, !q_stat.full, "push into full queue")
    `FSMATCH_ASSERT_NOW(a_found_no_ovf, res_hit, !result_data.overflow, "match with overflow")
    `FSMATCH_ASSERT_NOW(a_miss_pos, res_miss, ~|result_data.match_position, "miss position")
    `FSMATCH_ASSERT_NEXT(a_load_no_result, pat_pop, !$rose(result_valid), "result after load")

endmodule

FILE: tb/sv/fsmatch_tb_pkg.sv
`timescale 1ns / 1ps

package fsmatch_tb_pkg;

    localparam int unsigned PAT_CAP  = 32;
    localparam int unsigned TEXT_CAP = 65536;

    class first_match_predictor;

        logic [7:0]  pat_mem [PAT_CAP];
        logic [5:0]  lps [PAT_CAP];
        logic [5:0]  pat_len    = '0;
        bit          pat_done   = 1'b0;
        logic [5:0]  build_len  = '0;
        logic [5:0]  search_len = '0;
        logic [16:0] text_pos   = '0;
        bit          matched    = 1'b0;

        fsmatch_pkg::result_t pending_results [$];
        int                   errors = 0;

        function void clear_search();
            search_len = '0;
            text_pos   = '0;
            matched    = 1'b0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // returns 1 when the beat did real work (not dropped or skipped)
        function bit note_item(fsmatch_pkg::item_t it);
            fsmatch_pkg::result_t res;
            logic [5:0]           k;
            logic [16:0]          start;
            bit                   used;
            if (it.mode == fsmatch_pkg::MODE_PATTERN)
            begin
                if (pat_done)
                begin
                    pat_done  = 1'b0;
                    pat_len   = '0;
                    build_len = '0;
                    clear_search();
                end
                used = (pat_len < PAT_CAP) || it.last;
                if (pat_len < PAT_CAP)
                begin
                    pat_mem[pat_len] = it.byte_value;
                    if (pat_len == 0)
                    begin
                        build_len = '0;
                        lps[0]    = '0;
                    end
                    else
                    begin
                        k = build_len;
                        while (k > 0 && k < PAT_CAP && pat_mem[k] != it.byte_value)
                            k = lps[k - 1];
                        if (k < pat_len && pat_mem[k] == it.byte_value)
                            k = k + 1;
                        build_len    = k;
                        lps[pat_len] = k;
                    end
                    pat_len = pat_len + 1;
                end
                if (it.last)
                    pat_done = 1'b1;
                return used;
            end

            if (!pat_done || pat_len == 0)
                return 1'b0;

            if (matched)
            begin
                if (it.last)
                    clear_search();
                return 1'b0;
            end

            if (text_pos < TEXT_CAP)
            begin
                k = search_len;
                while (k > 0 && k < pat_len && pat_mem[k] != it.byte_value)
                    k = lps[k - 1];
                if (k < pat_len && pat_mem[k] == it.byte_value)
                    k = k + 1;
                if (k >= pat_len)
                begin
                    start = text_pos + 17'd1 - {11'd0, pat_len};
                    res.found          = 1'b1;
                    res.match_position = start[15:0];
                    res.overflow       = 1'b0;
                    pending_results.push_back(res);
                    if (it.last)
                        clear_search();
                    else
                    begin
                        search_len = '0;
                        matched    = 1'b1;
                    end
                    return 1'b1;
                end
                search_len = k;
                text_pos   = text_pos + 1;
            end
            else
            begin
                // saturate one past the cap to mark overflow
                text_pos = 17'(TEXT_CAP + 1);
            end

            if (it.last)
            begin
                res.found          = 1'b0;
                res.match_position = '0;
                res.overflow       = (text_pos > TEXT_CAP);
                pending_results.push_back(res);
                clear_search();
            end
            return 1'b1;
        endfunction

        function void check_result(fsmatch_pkg::result_t got);
            fsmatch_pkg::result_t want;
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: found=%0d pos=%0d overflow=%0d",
                             got.found, got.match_position, got.overflow);
                return;
            end
            want = pending_results.pop_front();
            if (got.found !== want.found || got.match_position !== want.match_position ||
                got.overflow !== want.overflow)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch found/pos/ovf: exp %0d/%0d/%0d got %0d/%0d/%0d",
                             want.found, want.match_position, want.overflow,
                             got.found, got.match_position, got.overflow);
            end
        endfunction

    endclass

endpackage

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 item_valid   = 1'b0;
    logic                 item_stall;
    fsmatch_pkg::item_t   item_data    = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    fsmatch_pkg::result_t result_data;

    fsmatch_tb_pkg::first_match_predictor sb;

    int         tx_idle_pct = 0;
    int         rx_idle_pct = 0;
    int         used_items  = 0;
    logic [7:0] alphabet [4];
    int         alphabet_n  = 1;

    first_substring_match_top #(
        .PATTERN_MAX(fsmatch_tb_pkg::PAT_CAP),
        .TEXT_MAX   (fsmatch_tb_pkg::TEXT_CAP)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item_data   (item_data),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result_data (result_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // result side: random stall, check every accepted beat
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result_data);
        result_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    task automatic send(input logic mode, input logic [7:0] bv, input logic last);
        fsmatch_pkg::item_t it;
        it.mode       = mode;
        it.byte_value = bv;
        it.last       = last;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item_data  <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        if (sb.note_item(it))
            used_items++;
    endtask

    function automatic logic [7:0] pick_symbol();
        return alphabet[$urandom_range(alphabet_n - 1)];
    endfunction

    // new pattern over a small alphabet, then a few text streams,
    // some with the pattern planted so matches and link walks happen
    task automatic run_pattern_and_text();
        logic [7:0] pat [$];
        logic [7:0] bv;
        int         plen;
        int         keep;
        int         tlen;
        int         plant_at;
        int         r;
        alphabet_n = $urandom_range(1, 4);
        for (int i = 0; i < 4; i++)
            alphabet[i] = 8'($urandom_range(255));
        r = $urandom_range(99);
        if (r < 70)
            plen = $urandom_range(1, 5);
        else if (r < 92)
            plen = $urandom_range(6, fsmatch_tb_pkg::PAT_CAP);
        else
            plen = $urandom_range(fsmatch_tb_pkg::PAT_CAP + 1, fsmatch_tb_pkg::PAT_CAP + 8);
        for (int i = 0; i < plen; i++)
        begin
            pat.push_back(pick_symbol());
            send(fsmatch_pkg::MODE_PATTERN, pat[i], i == plen - 1);
        end
        keep = (plen > fsmatch_tb_pkg::PAT_CAP) ? fsmatch_tb_pkg::PAT_CAP : plen;
        repeat ($urandom_range(1, 3))
        begin
            tlen = $urandom_range(1, 40);
            plant_at = -1;
            if ($urandom_range(1))
                plant_at = $urandom_range(0, tlen - 1);
            for (int i = 0; i < tlen; i++)
            begin
                bv = pick_symbol();
                if (plant_at >= 0 && i >= plant_at && i - plant_at < keep)
                    bv = pat[i - plant_at];
                send(fsmatch_pkg::MODE_TEXT, bv, i == tlen - 1);
            end
        end
    endtask

    task automatic run_noise();
        repeat ($urandom_range(1, 8))
            send(1'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    task automatic run_broken_sequence();
        int n;
        n = $urandom_range(1, 4);
        if ($urandom_range(1))
        begin
            // text while the pattern is still open gets dropped
            repeat (n)
                send(fsmatch_pkg::MODE_PATTERN, 8'($urandom_range(255)), 1'b0);
            repeat ($urandom_range(1, 3))
                send(fsmatch_pkg::MODE_TEXT, 8'($urandom_range(255)), 1'($urandom_range(1)));
            send(fsmatch_pkg::MODE_PATTERN, 8'($urandom_range(255)), 1'b1);
        end
        else
        begin
            // text stream left open, cut off by the next pattern
            send(fsmatch_pkg::MODE_PATTERN, 8'($urandom_range(255)), 1'b1);
            repeat (n)
                send(fsmatch_pkg::MODE_TEXT, 8'($urandom_range(255)), 1'b0);
        end
    endtask

    task automatic run_random_until(input int target);
        int r;
        while (used_items < target)
        begin
            r = $urandom_range(99);
            if (r < 80)
                run_pattern_and_text();
            else if (r < 90)
                run_noise();
            else
                run_broken_sequence();
        end
    endtask

    initial
    begin
        #(40_000_000);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 22;
        rx_idle_pct = 53;

        // text before any pattern is dropped
        send(fsmatch_pkg::MODE_TEXT, 8'h41, 1'b0);
        send(fsmatch_pkg::MODE_TEXT, 8'h42, 1'b1);
        send(fsmatch_pkg::MODE_PATTERN, 8'h00, 1'b0);
        send(fsmatch_pkg::MODE_PATTERN, 8'hFF, 1'b0);
        send(fsmatch_pkg::MODE_PATTERN, 8'h00, 1'b1);
        // match at index 1, rest of the stream skipped
        send(fsmatch_pkg::MODE_TEXT, 8'hFF, 1'b0);
        send(fsmatch_pkg::MODE_TEXT, 8'h00, 1'b0);
        send(fsmatch_pkg::MODE_TEXT, 8'hFF, 1'b0);
        send(fsmatch_pkg::MODE_TEXT, 8'h00, 1'b0);
        send(fsmatch_pkg::MODE_TEXT, 8'h11, 1'b0);
        send(fsmatch_pkg::MODE_TEXT, 8'h00, 1'b1);
        // no match
        send(fsmatch_pkg::MODE_TEXT, 8'h00, 1'b0);
        send(fsmatch_pkg::MODE_TEXT, 8'h00, 1'b1);
        // match completes on the last beat
        send(fsmatch_pkg::MODE_TEXT, 8'h00, 1'b0);
        send(fsmatch_pkg::MODE_TEXT, 8'hFF, 1'b0);
        send(fsmatch_pkg::MODE_TEXT, 8'h00, 1'b1);
        // new pattern in the middle of a text stream
        send(fsmatch_pkg::MODE_TEXT, 8'hFF, 1'b0);
        send(fsmatch_pkg::MODE_PATTERN, 8'hFF, 1'b1);
        send(fsmatch_pkg::MODE_TEXT, 8'h00, 1'b0);
        send(fsmatch_pkg::MODE_TEXT, 8'hFF, 1'b1);

        run_random_until(217);

        tx_idle_pct = 53;
        rx_idle_pct = 22;
        run_random_until(434);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random_until(650);

        // match right at the first text byte
        send(fsmatch_pkg::MODE_PATTERN, 8'h5A, 1'b0);
        send(fsmatch_pkg::MODE_PATTERN, 8'hA5, 1'b1);
        send(fsmatch_pkg::MODE_TEXT, 8'h5A, 1'b0);
        send(fsmatch_pkg::MODE_TEXT, 8'hA5, 1'b1);

        item_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (sb.pending() != 0)
        begin
            $display("%0d expected results never arrived", sb.pending());
            sb.errors += sb.pending();
        end
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/fsmatch_pkg.sv
rtl/core/fsmatch_front.sv
rtl/core/fsmatch_queue.sv
rtl/core/fsmatch_back.sv
rtl/core/first_substring_match_top.sv
tb/sv/fsmatch_tb_pkg.sv
tb/sv/testbench.sv
